FILE: hw/rtl/vbd_pkg.sv
// Shared types, constants and trellis functions for the K=4 block Viterbi decoder.
package vbd_pkg;

    localparam int NUM_STATES = 8;
    localparam int STATE_W    = 3;
    localparam int NUM_STEPS  = 7;
    localparam int TOP_BIT    = 13;
    localparam int BLOCK_W    = 14;
    localparam int METRIC_W   = 4;

    typedef logic [METRIC_W-1:0] metric_t;
    typedef logic [STATE_W-1:0]  state_t;
    typedef logic [1:0]          pair_t;

    typedef struct packed {
        logic [BLOCK_W-1:0]                      block;
        logic [NUM_STATES-1:0]                   alive;
        metric_t [NUM_STATES-1:0]                metric;
        logic [NUM_STEPS-1:0][NUM_STATES-1:0]    choose_odd;
    } stage_t;

    // Code pair (first bit high) for a state and an input bit, generators 17 and 15.
    localparam pair_t BRANCH_CODE [0:2*NUM_STATES-1] = '{
        2'd0, 2'd3, 2'd3, 2'd0, 2'd2, 2'd1, 2'd1, 2'd2,
        2'd3, 2'd0, 2'd0, 2'd3, 2'd1, 2'd2, 2'd2, 2'd1
    };

    function automatic logic [1:0] pair_distance(input pair_t a, input pair_t b);
        pair_t x;
        x = a ^ b;
        return {1'b0, x[0]} + {1'b0, x[1]};
    endfunction

endpackage

FILE: hw/rtl/vbd_coded_if.sv
// Stream interface carrying one coded block per transfer.
interface vbd_coded_if;
    logic                        valid;
    logic                        ready;
    logic [vbd_pkg::BLOCK_W-1:0] coded_block;

    modport source (output valid, output coded_block, input ready);
    modport sink   (input valid, input coded_block, output ready);
endinterface

FILE: hw/rtl/vbd_decoded_if.sv
// Stream interface carrying seven decoded bits per transfer.
interface vbd_decoded_if;
    logic                          valid;
    logic                          ready;
    logic [vbd_pkg::NUM_STEPS-1:0] decoded_bits;

    modport source (output valid, output decoded_bits, input ready);
    modport sink   (input valid, input decoded_bits, output ready);
endinterface

FILE: hw/rtl/viterbi_block_decoder_k4.sv
// Top level of the hard-decision rate-1/2 K=4 block Viterbi decoder.
// Each transfer on coded carries seven received symbol pairs, step one in bits 13:12, and
// produces one transfer on decoded with seven bits, step one in bit 0. The trellis starts
// in state 0 for every block and nothing is carried between blocks. Seven registered
// add-compare-select cells, one per trellis step, hand path metrics and survivor decisions
// down the chain, followed by a stage that picks the best end state and traces back. A new
// block is taken every cycle while decoded is ready; each accepted block is registered in
// each of the seven cells in turn, and its result in the traceback stage.
module viterbi_block_decoder_k4 (
    input  logic          clk,
    input  logic          rst_n,
    vbd_coded_if.sink     coded,
    vbd_decoded_if.source decoded
);

    logic            link_valid [0:vbd_pkg::NUM_STEPS];
    logic            link_ready [0:vbd_pkg::NUM_STEPS];
    vbd_pkg::stage_t link_data  [0:vbd_pkg::NUM_STEPS];
    vbd_pkg::stage_t first_stage;

    always_comb
    begin
        first_stage       = '0;
        first_stage.block = coded.coded_block;
        first_stage.alive = vbd_pkg::NUM_STATES'(1);
    end

    assign link_data[0]  = first_stage;
    assign link_valid[0] = coded.valid;
    assign coded.ready   = link_ready[0];

    for (genvar i = 0; i < vbd_pkg::NUM_STEPS; i++)
    begin : g_cell
        vbd_acs_cell #(
            .STEP (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (link_valid[i]),
            .up_ready   (link_ready[i]),
            .up_data    (link_data[i]),
            .down_valid (link_valid[i+1]),
            .down_ready (link_ready[i+1]),
            .down_data  (link_data[i+1])
        );
    end

    vbd_traceback u_traceback (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (link_valid[vbd_pkg::NUM_STEPS]),
        .up_ready   (link_ready[vbd_pkg::NUM_STEPS]),
        .up_data    (link_data[vbd_pkg::NUM_STEPS]),
        .down_valid (decoded.valid),
        .down_ready (decoded.ready),
        .down_bits  (decoded.decoded_bits)
    );

endmodule

FILE: hw/rtl/vbd_acs_cell.sv
// One registered add-compare-select cell handling a single trellis step.
module vbd_acs_cell #(
    parameter int STEP = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    output logic            up_ready,
    input  vbd_pkg::stage_t up_data,
    output logic            down_valid,
    input  logic            down_ready,
    output vbd_pkg::stage_t down_data
);

    logic            valid_reg;
    logic            valid_next;
    vbd_pkg::stage_t data_reg;
    vbd_pkg::stage_t data_next;

    always_comb
    begin
        vbd_pkg::pair_t   rx;
        vbd_pkg::state_t  pe;
        vbd_pkg::state_t  po;
        logic             u;
        vbd_pkg::metric_t ce;
        vbd_pkg::metric_t co;
        rx = up_data.block[vbd_pkg::TOP_BIT - 2*STEP -: 2];
        data_next = up_data;
        for (int n = 0; n < vbd_pkg::NUM_STATES; n++)
        begin
            u  = n[2];
            pe = {n[1:0], 1'b0};
            po = {n[1:0], 1'b1};
            ce = up_data.metric[pe] + vbd_pkg::metric_t'(vbd_pkg::pair_distance(
                     rx, vbd_pkg::BRANCH_CODE[{pe, u}]));
            co = up_data.metric[po] + vbd_pkg::metric_t'(vbd_pkg::pair_distance(
                     rx, vbd_pkg::BRANCH_CODE[{po, u}]));
            data_next.choose_odd[STEP][n] = 1'b0;
            data_next.alive[n]            = up_data.alive[pe] | up_data.alive[po];
            if (up_data.alive[pe] && up_data.alive[po])
            begin
                if (co < ce)
                begin
                    data_next.metric[n]           = co;
                    data_next.choose_odd[STEP][n] = 1'b1;
                end
                else
                begin
                    data_next.metric[n] = ce;
                end
            end
            else if (up_data.alive[pe])
            begin
                data_next.metric[n] = ce;
            end
            else if (up_data.alive[po])
            begin
                data_next.metric[n]           = co;
                data_next.choose_odd[STEP][n] = 1'b1;
            end
            else
            begin
                data_next.metric[n] = '0;
            end
        end
    end

    assign up_ready   = !valid_reg || down_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign down_valid = valid_reg;
    assign down_data  = data_reg;

endmodule

FILE: hw/rtl/vbd_traceback.sv
// Best end-state selection and traceback into a registered output.
module vbd_traceback (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    output logic            up_ready,
    input  vbd_pkg::stage_t up_data,
    output logic            down_valid,
    input  logic            down_ready,
    output logic [vbd_pkg::NUM_STEPS-1:0] down_bits
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [vbd_pkg::NUM_STEPS-1:0] bits_reg;
    logic [vbd_pkg::NUM_STEPS-1:0] bits_next;

    always_comb
    begin
        vbd_pkg::state_t  best;
        vbd_pkg::metric_t best_metric;
        logic             found;
        vbd_pkg::state_t  st;
        best        = '0;
        best_metric = '0;
        found       = 1'b0;
        for (int n = 0; n < vbd_pkg::NUM_STATES; n++)
        begin
            if (up_data.alive[n] && (!found || up_data.metric[n] < best_metric))
            begin
                best        = vbd_pkg::state_t'(n);
                best_metric = up_data.metric[n];
                found       = 1'b1;
            end
        end
        st        = best;
        bits_next = '0;
        for (int k = vbd_pkg::NUM_STEPS - 1; k >= 0; k--)
        begin
            bits_next[k] = st[2];
            st = {st[1:0], up_data.choose_odd[k][st]};
        end
    end

    assign up_ready   = !valid_reg || down_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            bits_reg <= bits_next;
        end
    end

    assign down_valid = valid_reg;
    assign down_bits  = bits_reg;

endmodule
